>>> design/lmc4_pkg.sv
// Shared types and constants for the 4-neighbour local minimum counter.
package lmc4_pkg;

  // configuration register
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd8;

  // minima count
  localparam int TOTAL_W = 13;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 13'h1FFF;

  // result kinds
  localparam logic KIND_MIN   = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  // slots of a result set, in delivery order
  localparam int RES_ABOVE  = 0;
  localparam int RES_LEFT   = 1;
  localparam int RES_CORNER = 2;
  localparam int RES_COUNT  = 3;
  localparam int RES_N      = 4;

  // position class of one element, worked out by the front
  typedef struct packed {
    logic has_up;     // row >= 1
    logic has_up2;    // row >= 2
    logic has_left;   // col >= 1
    logic has_left2;  // col >= 2
    logic has_right;  // col + 1 < n
    logic bottom;     // row == n - 1
    logic last_col;   // col == n - 1
    logic end_mat;    // final element of the matrix
  } item_flags_t;

endpackage

>>> design/lmc4_ram.sv
// Generic RAM: one write port, two registered read ports.
module lmc4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                     rdata_a,
  output logic [WIDTH-1:0]                     rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> design/lmc4_queue.sv
// Short FIFO between the front and the back.
module lmc4_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/lmc4_front.sv
// Front: size register, row/column counters and position classification.
module lmc4_front import lmc4_pkg::*; #(
  parameter int MAX_SIZE = 64
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       cfg_wr_en,
  input  logic [CFG_W-1:0]                           cfg_matrix_size,
  input  logic                                       in_push,
  input  logic                                       q_full,
  output logic                                       accept,
  output logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] row,
  output logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] col,
  output item_flags_t                                flags
);

  localparam int PosW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int SizeW = $clog2(MAX_SIZE + 1);

  logic [SizeW-1:0] n_r;
  logic [PosW-1:0]  row_r, row_nxt;
  logic [PosW-1:0]  col_r, col_nxt;
  logic [SizeW-1:0] row_inc, col_inc;

  // 0 acts as 1, anything above MAX_SIZE as MAX_SIZE
  function automatic logic [SizeW-1:0] size_clamp(input logic [CFG_W-1:0] s);
    if (s == '0) begin
      return SizeW'(1);
    end else if (int'(s) > MAX_SIZE) begin
      return SizeW'(MAX_SIZE);
    end else begin
      return SizeW'(s);
    end
  endfunction

  assign accept  = in_push && !q_full;
  assign row     = row_r;
  assign col     = col_r;
  assign row_inc = SizeW'(row_r) + SizeW'(1);
  assign col_inc = SizeW'(col_r) + SizeW'(1);

  always_comb begin
    flags.has_up    = (row_r != '0);
    flags.has_up2   = (row_r > PosW'(1));
    flags.has_left  = (col_r != '0);
    flags.has_left2 = (col_r > PosW'(1));
    flags.has_right = (col_inc < n_r);
    flags.bottom    = (row_inc == n_r);
    flags.last_col  = (col_inc == n_r);
    flags.end_mat   = flags.bottom && flags.last_col;
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (flags.last_col) begin
        col_nxt = '0;
        row_nxt = flags.bottom ? '0 : row_r + PosW'(1);
      end else begin
        col_nxt = col_r + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= size_clamp(CFG_SIZE_RESET);
      row_r <= '0;
      col_r <= '0;
    end else if (cfg_wr_en) begin
      n_r   <= size_clamp(cfg_matrix_size);
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // counters never leave the matrix
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (SizeW'(row_r) < n_r) && (SizeW'(col_r) < n_r))
    else $error("position counter outside matrix");

endmodule

>>> design/lmc4_eval.sv
// Back, evaluate part: row store RAM, neighbour window and minimum tests.
module lmc4_eval import lmc4_pkg::*; #(
  parameter int MAX_SIZE   = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       cnt_clear,
  input  logic                                       q_valid,
  input  logic signed [VALUE_BITS-1:0]               q_value,
  input  logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] q_row,
  input  logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] q_col,
  input  item_flags_t                                q_flags,
  output logic                                       q_pop,
  output logic                                       bundle_valid,
  input  logic                                       bundle_ready,
  output logic [RES_N-1:0]                           b_mask,
  output logic signed [VALUE_BITS-1:0]               b_value,
  output logic signed [VALUE_BITS-1:0]               b_prev,
  output logic signed [VALUE_BITS-1:0]               b_cur1,
  output logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] b_row,
  output logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] b_col,
  output logic [TOTAL_W-1:0]                         b_total
);

  localparam int PosW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int VB   = VALUE_BITS;

  // RAM entry per column: {row above, two rows above}
  logic [2*VB-1:0] rd_a, rd_b, wr_data;
  logic [PosW-1:0] raddr_b;

  logic                 s1_valid_r;
  logic signed [VB-1:0] s1_value_r;
  logic [PosW-1:0]      s1_row_r, s1_col_r;
  item_flags_t          s1_flags_r;
  logic                 byp_a_r, byp_b_r;
  logic [2*VB-1:0]      byp_data_r;
  logic signed [VB-1:0] prevl_r, cur1_r, cur2_r;
  logic [TOTAL_W-1:0]   cnt_r, cnt_nxt;

  logic signed [VB-1:0] prev_c, two_c, prev_r1;
  logic                 above_ok, left_ok, corner_ok;
  logic [1:0]           found_n;
  logic [TOTAL_W:0]     cnt_sum;
  logic [TOTAL_W-1:0]   cnt_sat;
  logic                 s1_fire;

  assign raddr_b = q_col + PosW'(1);
  assign wr_data = {s1_value_r, prev_c};

  lmc4_ram #(
    .WIDTH (2 * VB),
    .DEPTH (MAX_SIZE)
  ) u_rows (
    .clk     (clk),
    .we      (s1_fire),
    .waddr   (s1_col_r),
    .wdata   (wr_data),
    .re      (q_pop),
    .raddr_a (q_col),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // forward a write that landed on the same column as the read
  assign prev_c  = byp_a_r ? byp_data_r[2*VB-1:VB] : rd_a[2*VB-1:VB];
  assign two_c   = byp_a_r ? byp_data_r[VB-1:0]    : rd_a[VB-1:0];
  assign prev_r1 = byp_b_r ? byp_data_r[2*VB-1:VB] : rd_b[2*VB-1:VB];

  always_comb begin
    above_ok = s1_flags_r.has_up &&
               (!s1_flags_r.has_up2   || prev_c < two_c) &&
               (!s1_flags_r.has_left  || prev_c < prevl_r) &&
               (!s1_flags_r.has_right || prev_c < prev_r1) &&
               (prev_c < s1_value_r);
    left_ok  = s1_flags_r.bottom && s1_flags_r.has_left &&
               (!s1_flags_r.has_up    || cur1_r < prevl_r) &&
               (!s1_flags_r.has_left2 || cur1_r < cur2_r) &&
               (cur1_r < s1_value_r);
    corner_ok = s1_flags_r.bottom && s1_flags_r.last_col &&
                (!s1_flags_r.has_up   || s1_value_r < prev_c) &&
                (!s1_flags_r.has_left || s1_value_r < cur1_r);
  end

  always_comb begin
    found_n = 2'(above_ok) + 2'(left_ok) + 2'(corner_ok);
    cnt_sum = {1'b0, cnt_r} + (TOTAL_W + 1)'(found_n);
    cnt_sat = (cnt_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : cnt_sum[TOTAL_W-1:0];
    cnt_nxt = s1_flags_r.end_mat ? '0 : cnt_sat;
  end

  always_comb begin
    b_mask             = '0;
    b_mask[RES_ABOVE]  = above_ok;
    b_mask[RES_LEFT]   = left_ok;
    b_mask[RES_CORNER] = corner_ok;
    b_mask[RES_COUNT]  = s1_flags_r.end_mat;
  end

  assign bundle_valid = s1_valid_r && (b_mask != '0);
  assign s1_fire      = s1_valid_r && (!bundle_valid || bundle_ready);
  assign q_pop        = q_valid && (!s1_valid_r || s1_fire);

  assign b_value = s1_value_r;
  assign b_prev  = prev_c;
  assign b_cur1  = cur1_r;
  assign b_row   = s1_row_r;
  assign b_col   = s1_col_r;
  assign b_total = cnt_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r      <= '0;
      byp_a_r    <= 1'b0;
      byp_b_r    <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (cnt_clear) begin
        cnt_r <= '0;
      end else if (s1_fire) begin
        cnt_r <= cnt_nxt;
      end
      if (q_pop) begin
        byp_a_r <= s1_fire && (s1_col_r == q_col);
        byp_b_r <= s1_fire && (s1_col_r == raddr_b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_value_r <= q_value;
      s1_row_r   <= q_row;
      s1_col_r   <= q_col;
      s1_flags_r <= q_flags;
      byp_data_r <= wr_data;
    end
    if (s1_fire) begin
      prevl_r <= prev_c;
      cur1_r  <= s1_value_r;
      cur2_r  <= cur1_r;
    end
  end

  // the count restarts after the last element of a matrix
  a_cnt_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_flags_r.end_mat |=> (cnt_r == '0))
    else $error("minima count not cleared after matrix end");

  // a left-neighbour or corner minimum only in the bottom row
  a_bottom_only: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && (left_ok || corner_ok) |-> s1_flags_r.bottom)
    else $error("bottom-row minimum outside bottom row");

endmodule

>>> design/lmc4_emit.sv
// Back, emit part: drains one result set into the output register.
module lmc4_emit import lmc4_pkg::*; #(
  parameter int MAX_SIZE   = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       bundle_valid,
  output logic                                       bundle_ready,
  input  logic [RES_N-1:0]                           b_mask,
  input  logic signed [VALUE_BITS-1:0]               b_value,
  input  logic signed [VALUE_BITS-1:0]               b_prev,
  input  logic signed [VALUE_BITS-1:0]               b_cur1,
  input  logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] b_row,
  input  logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] b_col,
  input  logic [TOTAL_W-1:0]                         b_total,
  output logic                                       out_empty,
  input  logic                                       out_pop,
  output logic                                       out_item_kind,
  output logic signed [VALUE_BITS-1:0]               out_min_value,
  output logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] out_min_row,
  output logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] out_min_column,
  output logic [TOTAL_W-1:0]                         out_minimum_total,
  output logic                                       out_last_of_run
);

  localparam int PosW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int VB   = VALUE_BITS;

  logic [RES_N-1:0]     mask_r, mask_after, pick;
  logic signed [VB-1:0] p_value_r, p_prev_r, p_cur1_r;
  logic [PosW-1:0]      p_row_r, p_col_r;
  logic [TOTAL_W-1:0]   p_total_r;
  logic                 load, take;

  logic                 out_valid_r;
  logic                 out_kind_r, out_kind_nxt;
  logic signed [VB-1:0] out_value_r, out_value_nxt;
  logic [PosW-1:0]      out_row_r, out_row_nxt;
  logic [PosW-1:0]      out_col_r, out_col_nxt;
  logic [TOTAL_W-1:0]   out_total_r, out_total_nxt;
  logic                 out_last_r;

  // lowest pending slot goes first
  assign pick         = mask_r & (~mask_r + RES_N'(1));
  assign load         = (mask_r != '0) && (!out_valid_r || out_pop);
  assign mask_after   = load ? (mask_r & ~pick) : mask_r;
  assign bundle_ready = (mask_after == '0);
  assign take         = bundle_valid && bundle_ready;

  always_comb begin
    out_kind_nxt  = KIND_MIN;
    out_value_nxt = '0;
    out_row_nxt   = '0;
    out_col_nxt   = '0;
    out_total_nxt = '0;
    if (pick[RES_ABOVE]) begin
      out_value_nxt = p_prev_r;
      out_row_nxt   = p_row_r - PosW'(1);
      out_col_nxt   = p_col_r;
    end else if (pick[RES_LEFT]) begin
      out_value_nxt = p_cur1_r;
      out_row_nxt   = p_row_r;
      out_col_nxt   = p_col_r - PosW'(1);
    end else if (pick[RES_CORNER]) begin
      out_value_nxt = p_value_r;
      out_row_nxt   = p_row_r;
      out_col_nxt   = p_col_r;
    end else begin
      out_kind_nxt  = KIND_COUNT;
      out_total_nxt = p_total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= take ? b_mask : mask_after;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_value_r <= b_value;
      p_prev_r  <= b_prev;
      p_cur1_r  <= b_cur1;
      p_row_r   <= b_row;
      p_col_r   <= b_col;
      p_total_r <= b_total;
    end
    if (load) begin
      out_kind_r  <= out_kind_nxt;
      out_value_r <= out_value_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
      out_total_r <= out_total_nxt;
      out_last_r  <= (mask_after == '0);
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_item_kind     = out_kind_r;
  assign out_min_value     = out_value_r;
  assign out_min_row       = out_row_r;
  assign out_min_column    = out_col_r;
  assign out_minimum_total = out_total_r;
  assign out_last_of_run   = out_last_r;

  // the count item closes its set
  a_count_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_COUNT) |-> out_last_r)
    else $error("count item not marked last");

endmodule

>>> design/local_minimum_counter_4n_top.sv
// Top level of the streaming 4-neighbour local minimum counter.
//
//  channel  | ports                                   | transfer when
//  ---------+-----------------------------------------+--------------------------
//  input    | in_push, in_full, in_element_value       | in_push && !in_full
//  result   | out_empty, out_pop, out_item_kind, ...   | out_pop && !out_empty
//  config   | cfg_wr_en, cfg_matrix_size               | cfg_wr_en
//
// One element is taken per cycle while the queue has room; the front
// classifies it and queues it, the back reads the row store (one dual-read
// RAM port pair) and tests neighbours. Results leave one per cycle while the
// receiver pops, so an element that causes several results holds the back
// until all but the last of them have been loaded into the output register.
// Reset (rst_n low, synchronous) clears control state only; the row store
// needs no clearing pass. Stalls on the result side back up through the queue.
module local_minimum_counter_4n_top import lmc4_pkg::*; #(
  parameter int MAX_SIZE   = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // configuration
  input  logic                                       cfg_wr_en,
  input  logic [CFG_W-1:0]                           cfg_matrix_size,
  // input channel
  input  logic                                       in_push,
  output logic                                       in_full,
  input  logic signed [VALUE_BITS-1:0]               in_element_value,
  // result channel
  output logic                                       out_empty,
  input  logic                                       out_pop,
  output logic                                       out_item_kind,
  output logic signed [VALUE_BITS-1:0]               out_min_value,
  output logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] out_min_row,
  output logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] out_min_column,
  output logic [TOTAL_W-1:0]                         out_minimum_total,
  output logic                                       out_last_of_run
);

  localparam int PosW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int FlagW   = $bits(item_flags_t);
  localparam int QW      = VALUE_BITS + 2 * PosW + FlagW;
  localparam int QDepth  = 2;

  // front -> queue
  logic            f_accept;
  logic [PosW-1:0] f_row, f_col;
  item_flags_t     f_flags;
  logic            q_full;

  // queue -> eval
  logic            q_valid, q_pop;
  logic [QW-1:0]   q_head;
  logic signed [VALUE_BITS-1:0] q_value;
  logic [PosW-1:0] q_row, q_col;
  item_flags_t     q_flags;

  // eval -> emit
  logic                         bundle_valid, bundle_ready;
  logic [RES_N-1:0]             b_mask;
  logic signed [VALUE_BITS-1:0] b_value, b_prev, b_cur1;
  logic [PosW-1:0]              b_row, b_col;
  logic [TOTAL_W-1:0]           b_total;

  assign in_full = q_full;

  lmc4_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_matrix_size (cfg_matrix_size),
    .in_push         (in_push),
    .q_full          (q_full),
    .accept          (f_accept),
    .row             (f_row),
    .col             (f_col),
    .flags           (f_flags)
  );

  // queue entry: {value, row, col, flags}
  lmc4_queue #(
    .WIDTH (QW),
    .DEPTH (QDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_accept),
    .push_data ({in_element_value, f_row, f_col, f_flags}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  assign q_value = q_head[QW-1 -: VALUE_BITS];
  assign q_row   = q_head[FlagW + 2*PosW - 1 -: PosW];
  assign q_col   = q_head[FlagW + PosW - 1 -: PosW];
  assign q_flags = item_flags_t'(q_head[FlagW-1:0]);

  lmc4_eval #(
    .MAX_SIZE   (MAX_SIZE),
    .VALUE_BITS (VALUE_BITS)
  ) u_eval (
    .clk          (clk),
    .rst_n        (rst_n),
    .cnt_clear    (cfg_wr_en),
    .q_valid      (q_valid),
    .q_value      (q_value),
    .q_row        (q_row),
    .q_col        (q_col),
    .q_flags      (q_flags),
    .q_pop        (q_pop),
    .bundle_valid (bundle_valid),
    .bundle_ready (bundle_ready),
    .b_mask       (b_mask),
    .b_value      (b_value),
    .b_prev       (b_prev),
    .b_cur1       (b_cur1),
    .b_row        (b_row),
    .b_col        (b_col),
    .b_total      (b_total)
  );

  lmc4_emit #(
    .MAX_SIZE   (MAX_SIZE),
    .VALUE_BITS (VALUE_BITS)
  ) u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .bundle_valid      (bundle_valid),
    .bundle_ready      (bundle_ready),
    .b_mask            (b_mask),
    .b_value           (b_value),
    .b_prev            (b_prev),
    .b_cur1            (b_cur1),
    .b_row             (b_row),
    .b_col             (b_col),
    .b_total           (b_total),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_item_kind     (out_item_kind),
    .out_min_value     (out_min_value),
    .out_min_row       (out_min_row),
    .out_min_column    (out_min_column),
    .out_minimum_total (out_minimum_total),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

>>> tb/sv/local_minimum_counter_4n_top_test.sv
// Self-checking testbench for the streaming 4-neighbour local minimum counter.
`timescale 1ns / 1ps

module local_minimum_counter_4n_top_test;
  import lmc4_pkg::*;

  localparam int MAX_SIZE      = 64;
  localparam int VAL_W         = 16;
  localparam int POS_W         = 6;
  localparam int IDLE_PCT      = 7;       // percent of cycles each side sits out
  localparam int HOLD_CYCLES   = 300;     // one long receiver hold-off
  localparam int SETTLE_CYCLES = 12;      // margin for the pipeline to clear
  localparam int RANDOM_ITEMS  = 150;
  // ~350 elements; even with every element stalled a few cycles and the
  // long hold-off the run stays well under this
  localparam int CYCLE_LIMIT   = 250000;

  // one result as it leaves the block
  typedef struct packed {
    logic               kind;
    logic [VAL_W-1:0]   value;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   column;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } report_t;

  // how the random matrices are filled
  typedef enum int unsigned {
    STYLE_WIDE,     // any 16-bit value
    STYLE_NARROW,   // -2..2, lots of ties
    STYLE_CHECKER,  // negatives on even cells, so every even cell is a minimum
    STYLE_EDGE      // only the extreme values and 0 / -1
  } fill_style_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_wr_en        = 1'b0;
  logic [CFG_W-1:0]       cfg_matrix_size  = '0;
  logic                   in_push          = 1'b0;
  logic                   in_full;
  logic signed [VAL_W-1:0] in_element_value = '0;
  logic                   out_empty;
  logic                   out_pop          = 1'b0;
  logic                   out_item_kind;
  logic signed [VAL_W-1:0] out_min_value;
  logic [POS_W-1:0]       out_min_row;
  logic [POS_W-1:0]       out_min_column;
  logic [TOTAL_W-1:0]     out_minimum_total;
  logic                   out_last_of_run;

  always #5 clk = ~clk;

  local_minimum_counter_4n_top #(
    .MAX_SIZE  (MAX_SIZE),
    .VALUE_BITS(VAL_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_matrix_size  (cfg_matrix_size),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_element_value (in_element_value),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_item_kind    (out_item_kind),
    .out_min_value    (out_min_value),
    .out_min_row      (out_min_row),
    .out_min_column   (out_min_column),
    .out_minimum_total(out_minimum_total),
    .out_last_of_run  (out_last_of_run)
  );

  // ---------------------------------------------------------------------------
  // Shared state between stimulus, driver and monitor
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] element_feed[$];     // elements waiting to be pushed
  report_t          expected_reports[$]; // results predicted, not yet popped

  bit no_idle        = 1'b0;  // both sides run flat out while set
  bit hold_request   = 1'b0;  // stimulus asks the monitor for one long hold-off
  bit hold_started   = 1'b0;
  int hold_left      = 0;

  int elements_sent  = 0;
  int reports_seen   = 0;
  int counts_seen    = 0;
  int in_stall_cycles = 0;
  int size_writes    = 0;
  int error_cnt      = 0;
  int cycle_count    = 0;

  // ---------------------------------------------------------------------------
  // Minimum predictor: row stores, scan position and running count
  // ---------------------------------------------------------------------------
  logic signed [VAL_W-1:0] grid_back2[MAX_SIZE];  // row r-2
  logic signed [VAL_W-1:0] grid_prev [MAX_SIZE];  // row r-1
  logic signed [VAL_W-1:0] grid_cur  [MAX_SIZE];  // row r
  int unsigned        scan_row      = 0;
  int unsigned        scan_col      = 0;
  logic [TOTAL_W-1:0] minima_so_far = '0;
  logic [CFG_W-1:0]   size_setting  = CFG_SIZE_RESET;
  report_t            step_batch[$];              // results of one element

  // size 0 behaves as 1, anything past the store depth as the full depth
  function automatic int unsigned active_size();
    if (size_setting == 0) return 1;
    if (size_setting > MAX_SIZE) return MAX_SIZE;
    return size_setting;
  endfunction

  // any size write drops the matrix in progress
  function automatic void set_size(input logic [CFG_W-1:0] s);
    size_setting  = s;
    scan_row      = 0;
    scan_col      = 0;
    minima_so_far = '0;
  endfunction

  function automatic void add_minimum(input logic signed [VAL_W-1:0] x,
                                      input int unsigned r, input int unsigned c);
    report_t rep;
    if (minima_so_far != TOTAL_MAX) minima_so_far++;
    rep        = '0;
    rep.kind   = KIND_MIN;
    rep.value  = x;
    rep.row    = r[POS_W-1:0];
    rep.column = c[POS_W-1:0];
    step_batch.push_back(rep);
  endfunction

  // Called on every input transfer. An element's minimum test resolves once
  // its last neighbour is in: the element above when the one below arrives,
  // and on the bottom row the left neighbour and the corner at once.
  function automatic void predict_element(input logic signed [VAL_W-1:0] v);
    int unsigned n;
    int unsigned r;
    int unsigned c;
    logic signed [VAL_W-1:0] x;
    report_t rep;
    n = active_size();
    r = scan_row;
    c = scan_col;
    step_batch.delete();
    if (r >= n || c >= n) begin
      r = 0;
      c = 0;
      minima_so_far = '0;
    end
    grid_cur[c] = v;

    if (r >= 1) begin
      x = grid_prev[c];
      if ((r < 2 || x < grid_back2[c]) && (c == 0 || x < grid_prev[c-1]) &&
          (c + 1 >= n || x < grid_prev[c+1]) && x < v)
        add_minimum(x, r - 1, c);
    end
    if (r == n - 1) begin
      if (c >= 1) begin
        x = grid_cur[c-1];
        if ((r == 0 || x < grid_prev[c-1]) && (c < 2 || x < grid_cur[c-2]) && x < v)
          add_minimum(x, r, c - 1);
      end
      if (c == n - 1 && (r == 0 || v < grid_prev[c]) && (c == 0 || v < grid_cur[c-1]))
        add_minimum(v, r, c);
    end

    if (c + 1 < n) begin
      c++;
    end else begin
      c = 0;
      grid_back2 = grid_prev;
      grid_prev  = grid_cur;
      if (r + 1 < n) begin
        r++;
      end else begin
        rep       = '0;
        rep.kind  = KIND_COUNT;
        rep.total = minima_so_far;
        step_batch.push_back(rep);
        r = 0;
        minima_so_far = '0;
      end
    end
    scan_row = r;
    scan_col = c;

    if (step_batch.size() > 0) step_batch[step_batch.size()-1].last = 1'b1;
    foreach (step_batch[i]) expected_reports.push_back(step_batch[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  function automatic void log_failure(input string what, input report_t want,
                                      input report_t got);
    error_cnt++;
    if (error_cnt <= 10)
      $display({"[%0t] %s: exp kind=%0d value=%0d row=%0d col=%0d total=%0d last=%0d",
                " | got kind=%0d value=%0d row=%0d col=%0d total=%0d last=%0d"},
               $time, what,
               want.kind, $signed(want.value), want.row, want.column, want.total,
               want.last,
               got.kind, $signed(got.value), got.row, got.column, got.total,
               got.last);
  endfunction

  function automatic void check_report(input report_t got);
    report_t want;
    reports_seen++;
    if (expected_reports.size() == 0) begin
      log_failure("result with nothing expected", '0, got);
      return;
    end
    want = expected_reports.pop_front();
    if (got.kind !== want.kind || got.value !== want.value || got.row !== want.row ||
        got.column !== want.column || got.total !== want.total || got.last !== want.last)
      log_failure("result mismatch", want, got);
    else if (got.kind == KIND_COUNT)
      counts_seen++;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pushes queued elements, holds each until its transfer, and runs
  // the prediction at the edge where the transfer happens.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : feed_driver
    logic             next_push;
    logic [VAL_W-1:0] next_value;
    next_push  = in_push;
    next_value = in_element_value;
    if (!rst_n) begin
      next_push = 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predict_element(in_element_value);
        elements_sent++;
        next_push = 1'b0;
      end else if (in_push) begin
        in_stall_cycles++;   // block is full, keep offering the same element
      end
      if (!next_push && element_feed.size() != 0 &&
          (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        next_push  = 1'b1;
        next_value = element_feed.pop_front();
      end
    end
    in_push          <= next_push;
    in_element_value <= next_value;
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer, drives pop with random gaps and
  // one long hold-off that lets the block back up into its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : report_monitor
    logic    next_pop;
    report_t seen;
    next_pop = 1'b0;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        seen.kind   = out_item_kind;
        seen.value  = out_min_value;
        seen.row    = out_min_row;
        seen.column = out_min_column;
        seen.total  = out_minimum_total;
        seen.last   = out_last_of_run;
        check_report(seen);
      end
      if (hold_request && !hold_started) begin
        hold_left    = HOLD_CYCLES;
        hold_started = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else begin
        next_pop = no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
    out_pop <= next_pop;
  end

  // run-away guard
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results still expected",
               cycle_count, expected_reports.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Wait until every queued element has transferred and every predicted result
  // has been popped, then give elements that produce no result time to clear.
  task automatic drain();
    @(negedge clk);
    while (element_feed.size() != 0 || in_push || expected_reports.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // size writes only happen with the block idle
  task automatic write_size(input int unsigned s);
    drain();
    @(posedge clk);
    cfg_wr_en       <= 1'b1;
    cfg_matrix_size <= s[CFG_W-1:0];
    @(posedge clk);   // block takes the write at this edge
    cfg_wr_en       <= 1'b0;
    set_size(s[CFG_W-1:0]);
    size_writes++;
    @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value(input fill_style_t style,
                                                  input int unsigned r,
                                                  input int unsigned c);
    case (style)
      STYLE_NARROW:  return VAL_W'($urandom_range(4) - 2);
      STYLE_CHECKER: return ((r + c) % 2 == 0) ? {1'b1, 15'($urandom)}
                                               : {1'b0, 15'($urandom)};
      STYLE_EDGE: begin
        case ($urandom_range(3))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default:       return VAL_W'($urandom);
    endcase
  endfunction

  // queue the first `count` elements of an n x n matrix
  function automatic void queue_matrix(input int unsigned n, input fill_style_t style,
                                       input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      element_feed.push_back(pick_value(style, i / n, i % n));
  endfunction

  function automatic void queue_list(input int vals[$]);
    foreach (vals[i]) element_feed.push_back(VAL_W'(vals[i]));
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned s;
    int unsigned n;
    int unsigned mats;
    int          random_items;
    int          phase;
    fill_style_t style;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed. Reset size (8): one row of extremes and ties, then the start
    // of row 1 so the top-left corner resolves as a minimum. The matrix is
    // left unfinished and dropped by the size write that follows.
    queue_list('{-32768, 32767, 0, -1, 5, 5, 32767, -32768, 32767, -32767});

    // size 0 acts as a 1x1 matrix: every element is a minimum and a count
    write_size(0);
    queue_list('{-32768, 32767});

    // 2x2 with minima on both diagonal corners, the second on the final element
    write_size(2);
    queue_list('{-1, 0, 0, -1});

    // 3x3 whose final element resolves the minimum above it and the one to its
    // left, then closes the matrix: three results from one transfer
    write_size(3);
    queue_list('{9, 9, 9, 9, 9, 1, 9, 1, 9});

    // Largest size, checkerboard: the top row and the start of the second, so
    // the even top-row cells of the first 16 columns come out as minima. The
    // receiver holds off at the start so the block fills and pushes back on the
    // input; the rest of the matrix is dropped by the next size write.
    write_size(MAX_SIZE);
    hold_request = 1'b1;
    queue_matrix(MAX_SIZE, STYLE_CHECKER, MAX_SIZE + 16);

    // largest register value (clamps to the store depth), dropped after a row and two elements
    write_size(127);
    queue_matrix(MAX_SIZE, STYLE_WIDE, MAX_SIZE + 2);

    write_size(1);
    queue_list('{0, -1, 1});

    // Random phases: mostly small sizes, whole matrices with random content,
    // sometimes a trailing partial matrix that the next write discards.
    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 0) begin
        s = 10;
      end else begin
        case ($urandom_range(9))
          0:       s = $urandom_range(9, 12);
          1:       s = $urandom_range(0, 1);
          default: s = $urandom_range(2, 8);
        endcase
      end
      write_size(s);
      no_idle = (phase == 0);   // one stretch with neither side idling
      n = (s == 0) ? 1 : s;
      mats = (phase == 0) ? 1 : $urandom_range(1, 3);
      for (int unsigned m = 0; m < mats && random_items < RANDOM_ITEMS; m++) begin
        style = fill_style_t'($urandom_range(3));
        queue_matrix(n, style, n * n);
        random_items += n * n;
      end
      if (random_items < RANDOM_ITEMS && $urandom_range(3) == 0) begin
        mats = $urandom_range(1, n * n);
        queue_matrix(n, fill_style_t'($urandom_range(3)), mats);
        random_items += mats;
      end
      phase++;
    end

    drain();
    no_idle = 1'b0;

    $display("Covered %0d elements over %0d size writes (0, 1, 2, 3, 64, 127 and random sizes)",
             elements_sent, size_writes);
    $display("Checked %0d results (%0d matrix counts); input held off %0d cycles by a full block",
             reports_seen, counts_seen, in_stall_cycles);
    if (error_cnt == 0 && expected_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures, %0d results never arrived", error_cnt, expected_reports.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
